FILE: rtl/bfba_pkg.sv
`default_nettype none

package bfba_pkg;

    // Fixed field widths of the configuration registers and stream fields.
    localparam int SIZE_W     = 16;
    localparam int COUNT_W    = 9;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;

    // The free bitmap is stored in rows of this many blocks.
    localparam int ROW_BITS   = 32;
    localparam int ROW_SH     = 5;

    // Operation codes carried in the input tuser.
    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_QUERY = 2'd2
    } opcode_t;

    // Result status codes carried in the output tuser.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK           = 2'd0,
        STATUS_FULL         = 2'd1,
        STATUS_NOT_BLOCK    = 2'd2,
        STATUS_ALREADY_FREE = 2'd3
    } status_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE  = 2'd0,
        CFG_SIZE  = 2'd1,
        CFG_COUNT = 2'd2
    } cfg_index_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ALLOC_RD,
        ST_ALLOC_CHK,
        ST_ALLOC_MUL,
        ST_ALLOC_ADD,
        ST_DIV,
        ST_FREE_RD,
        ST_FREE_CHK,
        ST_DONE
    } state_t;

    // Status of the address locator returned to the sequencer.
    typedef struct packed {
        logic done;
        logic exact;
        logic in_range;
    } div_res_t;

endpackage

`default_nettype wire

FILE: rtl/bfba_ram.sv
`default_nettype none

module bfba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/bfba_div.sv
`default_nettype none

module bfba_div #(
    parameter int ADDR_WIDTH = 32,
    parameter int IDX_W      = 8,
    parameter int CNT_W      = 9
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [ADDR_WIDTH-1:0]      dividend,
    input  wire logic [bfba_pkg::SIZE_W-1:0] divisor,
    input  wire logic [CNT_W-1:0]           limit,
    output bfba_pkg::div_res_t              res,
    output logic      [IDX_W-1:0]           idx
);

    localparam int SW     = bfba_pkg::SIZE_W;
    localparam int STEP_W = $clog2(ADDR_WIDTH);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SW-1:0]     rem_reg, rem_next;
    logic [SW-1:0]     dvs_reg, dvs_next;
    logic [ADDR_WIDTH-1:0] quo_reg, quo_next;

    logic [SW:0] trial;
    logic [SW:0] diff;
    logic        ge;

    // One restoring-division step: shift in the next dividend bit and subtract.
    assign trial = {rem_reg, quo_reg[ADDR_WIDTH-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[SW-1:0] : trial[SW-1:0];
            quo_next  = {quo_reg[ADDR_WIDTH-2:0], ge};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(ADDR_WIDTH - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    // The address is a block start when the remainder is zero and the quotient
    // names an active block. Fields are done, exact and in_range from the top bit.
    assign res = {done_reg, (rem_reg == '0), (quo_reg < ADDR_WIDTH'(limit))};
    assign idx = quo_reg[IDX_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/bitmap_fixed_block_allocator_top.sv
`default_nettype none

// Fixed-size block allocator over a free bitmap.
// Input stream: tuser carries the operation (allocate, free, query) and tdata the
// block address used by free and query. Each accepted transaction produces exactly
// one result transaction: tuser carries the status, tdata the allocated block
// address and the number of blocks in use after the operation.
// The block handles one transaction at a time: s_axis_tready is high only while
// idle, and the next transaction is taken in the cycle after the result is taken.
// Allocate scans the bitmap one 32-block row at a time, reading each row and then
// checking it, up to the last row that holds an active block; a found free block
// is turned into its address by a multiply and then an add. Free and query run
// a bit-serial divide of the address offset by the block size, one quotient bit per
// cycle; a free that names an active block start then reads its bitmap row and
// marks the block free unless it already is.
// If the receiver stalls, the result is held on the master side and no new
// transaction is accepted until it is taken.
// Reset marks every block free, clears the used count and loads the registers
// with base address 0, block size 1 and block count 256. The configuration port
// must only be written while the block is idle.
module bitmap_fixed_block_allocator_top #(
    parameter int MAX_BLOCKS = 256,
    parameter int ADDR_WIDTH = 32
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Configuration write port.
    input  wire logic                           cfg_we,
    input  wire logic [bfba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ADDR_WIDTH-1:0]          cfg_data,
    // Input stream.
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: address
    input  wire logic [((ADDR_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // tuser: opcode
    input  wire logic [bfba_pkg::OP_W-1:0]      s_axis_tuser,
    // Result stream.
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // tdata: block_address, used_count
    output logic [((ADDR_WIDTH+bfba_pkg::COUNT_W+7)/8)*8-1:0] m_axis_tdata,
    // tuser: status
    output logic [bfba_pkg::STATUS_W-1:0]       m_axis_tuser
);

    localparam int ROW_BITS  = bfba_pkg::ROW_BITS;
    localparam int ROW_SH    = bfba_pkg::ROW_SH;
    localparam int SW        = bfba_pkg::SIZE_W;
    localparam int CW        = bfba_pkg::COUNT_W;
    localparam int ROWS      = (MAX_BLOCKS + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int RAM_DEPTH = 2 ** ROW_AW;
    localparam int IDX_W     = ROW_AW + ROW_SH;
    localparam int CNT_W     = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W     = (CNT_W > CW) ? CNT_W : CW;
    localparam int PROD_W    = IDX_W + SW;
    localparam int OUT_W     = ((ADDR_WIDTH + CW + 7) / 8) * 8;

    bfba_pkg::state_t  state_reg, state_next;
    bfba_pkg::status_t status_reg, status_next;

    logic [ADDR_WIDTH-1:0] base_reg, base_next;
    logic [SW-1:0]         size_reg, size_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [SW-1:0]         sz_reg, sz_next;
    logic                  is_free_reg, is_free_next;
    logic [ROW_AW-1:0]     row_reg, row_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [ADDR_WIDTH-1:0] res_addr_reg, res_addr_next;
    logic [CNT_W-1:0]      total_reg, total_next;
    logic [RAM_DEPTH-1:0]  valid_reg, valid_next;

    logic                  s_fire;
    logic [ADDR_WIDTH-1:0] in_address;
    logic [SW-1:0]         sz_eff;
    logic [CMP_W-1:0]      count_wide;
    logic [CNT_W-1:0]      n_eff;
    logic                  div_start;
    bfba_pkg::div_res_t    div_res;
    logic [IDX_W-1:0]      div_idx;

    logic                  ram_we;
    logic [ROW_AW-1:0]     cur_row;
    logic [ROW_BITS-1:0]   ram_wdata;
    logic [ROW_BITS-1:0]   ram_rdata;
    logic [ROW_BITS-1:0]   eff_row;
    logic [ROW_BITS-1:0]   cand;
    logic                  alloc_hit;
    logic [ROW_SH-1:0]     hit_pos;
    logic [IDX_W:0]        next_start;
    logic                  scan_end;
    logic [ROW_SH-1:0]     free_bit;

    assign s_fire     = s_axis_tvalid && s_axis_tready;
    assign in_address = s_axis_tdata[ADDR_WIDTH-1:0];
    assign sz_eff     = (size_reg == '0) ? SW'(1) : size_reg;

    // Active block count, saturated to the built maximum.
    assign count_wide = CMP_W'(count_reg);
    assign n_eff      = (count_wide > CMP_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                           : CNT_W'(count_wide);

    // Shared serial divider locating the block of an address.
    assign div_start = (state_reg == bfba_pkg::ST_IDLE) && s_fire &&
                       ((s_axis_tuser == bfba_pkg::OP_FREE) ||
                        (s_axis_tuser == bfba_pkg::OP_QUERY));

    bfba_div #(
        .ADDR_WIDTH (ADDR_WIDTH),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (in_address - base_reg),
        .divisor  (sz_eff),
        .limit    (n_eff),
        .res      (div_res),
        .idx      (div_idx)
    );

    // Free bitmap row storage; a row never written reads as all free.
    assign cur_row = ((state_reg == bfba_pkg::ST_FREE_RD) ||
                      (state_reg == bfba_pkg::ST_FREE_CHK)) ? idx_reg[IDX_W-1:ROW_SH]
                                                             : row_reg;

    bfba_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cur_row),
        .wdata (ram_wdata),
        .raddr (cur_row),
        .rdata (ram_rdata)
    );

    assign eff_row = valid_reg[cur_row] ? ram_rdata : '1;

    // Free blocks of the current row that lie below the active count.
    always_comb begin
        for (int j = 0; j < ROW_BITS; j++) begin
            cand[j] = eff_row[j] &&
                      ({1'b0, row_reg, ROW_SH'(j)} < (IDX_W+1)'(n_eff));
        end
    end

    // Lowest free candidate in the row.
    always_comb begin
        alloc_hit = 1'b0;
        hit_pos   = '0;
        for (int j = ROW_BITS - 1; j >= 0; j--) begin
            if (cand[j]) begin
                alloc_hit = 1'b1;
                hit_pos   = ROW_SH'(j);
            end
        end
    end

    assign next_start = {(ROW_AW+1)'({1'b0, row_reg}) + (ROW_AW+1)'(1), {ROW_SH{1'b0}}};
    assign scan_end   = next_start >= (IDX_W+1)'(n_eff);
    assign free_bit   = idx_reg[ROW_SH-1:0];

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bfba_pkg::ST_IDLE: begin
                if (s_fire) begin
                    case (s_axis_tuser)
                        bfba_pkg::OP_ALLOC: state_next = bfba_pkg::ST_ALLOC_RD;
                        bfba_pkg::OP_FREE:  state_next = bfba_pkg::ST_DIV;
                        bfba_pkg::OP_QUERY: state_next = bfba_pkg::ST_DIV;
                        default:            state_next = bfba_pkg::ST_DONE;
                    endcase
                end
            end
            bfba_pkg::ST_ALLOC_RD:  state_next = bfba_pkg::ST_ALLOC_CHK;
            bfba_pkg::ST_ALLOC_CHK: begin
                if (alloc_hit) begin
                    state_next = bfba_pkg::ST_ALLOC_MUL;
                end else if (scan_end) begin
                    state_next = bfba_pkg::ST_DONE;
                end else begin
                    state_next = bfba_pkg::ST_ALLOC_RD;
                end
            end
            bfba_pkg::ST_ALLOC_MUL: state_next = bfba_pkg::ST_ALLOC_ADD;
            bfba_pkg::ST_ALLOC_ADD: state_next = bfba_pkg::ST_DONE;
            bfba_pkg::ST_DIV: begin
                if (div_res.done) begin
                    if (div_res.exact && div_res.in_range && is_free_reg) begin
                        state_next = bfba_pkg::ST_FREE_RD;
                    end else begin
                        state_next = bfba_pkg::ST_DONE;
                    end
                end
            end
            bfba_pkg::ST_FREE_RD:  state_next = bfba_pkg::ST_FREE_CHK;
            bfba_pkg::ST_FREE_CHK: state_next = bfba_pkg::ST_DONE;
            bfba_pkg::ST_DONE: begin
                if (m_axis_tready) begin
                    state_next = bfba_pkg::ST_IDLE;
                end
            end
            default: state_next = bfba_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory control driven by the sequencer state.
    always_comb begin
        status_next   = status_reg;
        sz_next       = sz_reg;
        is_free_next  = is_free_reg;
        row_next      = row_reg;
        idx_next      = idx_reg;
        prod_next     = prod_reg;
        res_addr_next = res_addr_reg;
        total_next    = total_reg;
        valid_next    = valid_reg;
        ram_we        = 1'b0;
        ram_wdata     = eff_row;
        case (state_reg)
            bfba_pkg::ST_IDLE: begin
                if (s_fire) begin
                    row_next      = '0;
                    sz_next       = sz_eff;
                    is_free_next  = (s_axis_tuser == bfba_pkg::OP_FREE);
                    res_addr_next = '0;
                    status_next   = bfba_pkg::STATUS_NOT_BLOCK;
                end
            end
            bfba_pkg::ST_ALLOC_CHK: begin
                if (alloc_hit) begin
                    ram_we              = 1'b1;
                    ram_wdata           = eff_row & ~(ROW_BITS'(1) << hit_pos);
                    valid_next[cur_row] = 1'b1;
                    idx_next            = {row_reg, hit_pos};
                    total_next          = total_reg + CNT_W'(1);
                end else if (scan_end) begin
                    status_next = bfba_pkg::STATUS_FULL;
                end else begin
                    row_next = row_reg + ROW_AW'(1);
                end
            end
            bfba_pkg::ST_ALLOC_MUL: begin
                prod_next = PROD_W'(idx_reg) * PROD_W'(sz_reg);
            end
            bfba_pkg::ST_ALLOC_ADD: begin
                res_addr_next = base_reg + ADDR_WIDTH'(prod_reg);
                status_next   = bfba_pkg::STATUS_OK;
            end
            bfba_pkg::ST_DIV: begin
                if (div_res.done) begin
                    idx_next = div_idx;
                    if (div_res.exact && div_res.in_range && !is_free_reg) begin
                        status_next = bfba_pkg::STATUS_OK;
                    end
                end
            end
            bfba_pkg::ST_FREE_CHK: begin
                if (eff_row[free_bit]) begin
                    status_next = bfba_pkg::STATUS_ALREADY_FREE;
                end else begin
                    ram_we              = 1'b1;
                    ram_wdata           = eff_row | (ROW_BITS'(1) << free_bit);
                    valid_next[cur_row] = 1'b1;
                    if (total_reg != '0) begin
                        total_next = total_reg - CNT_W'(1);
                    end
                    status_next = bfba_pkg::STATUS_OK;
                end
            end
            default: begin
            end
        endcase
    end

    // Configuration register writes.
    always_comb begin
        base_next  = base_reg;
        size_next  = size_reg;
        count_next = count_reg;
        if (cfg_we) begin
            case (cfg_index)
                bfba_pkg::CFG_BASE:  base_next  = cfg_data;
                bfba_pkg::CFG_SIZE:  size_next  = cfg_data[SW-1:0];
                bfba_pkg::CFG_COUNT: count_next = cfg_data[CW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= bfba_pkg::ST_IDLE;
            base_reg   <= '0;
            size_reg   <= SW'(1);
            count_reg  <= CW'(256);
            total_reg  <= '0;
            valid_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            base_reg   <= base_next;
            size_reg   <= size_next;
            count_reg  <= count_next;
            total_reg  <= total_next;
            valid_reg  <= valid_next;
        end
        status_reg   <= status_next;
        sz_reg       <= sz_next;
        is_free_reg  <= is_free_next;
        row_reg      <= row_next;
        idx_reg      <= idx_next;
        prod_reg     <= prod_next;
        res_addr_reg <= res_addr_next;
    end

    // Stream outputs.
    assign s_axis_tready = (state_reg == bfba_pkg::ST_IDLE);
    assign m_axis_tvalid = (state_reg == bfba_pkg::ST_DONE);
    assign m_axis_tdata  = OUT_W'({CW'(total_reg), res_addr_reg});
    assign m_axis_tuser  = status_reg;

    // The block never takes new input while a result is pending.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input accepted while a result is pending");

    // The used count can never exceed the number of blocks built.
    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= CNT_W'(MAX_BLOCKS))
        else $error("used count above the pool size");

    // A failed allocation reports a zero address.
    a_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (status_reg == bfba_pkg::STATUS_FULL)) |-> (res_addr_reg == '0))
        else $error("failed allocation with nonzero address");

    // A found free block raises the used count by one.
    a_alloc_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == bfba_pkg::ST_ALLOC_CHK) && alloc_hit) |=>
        (total_reg == $past(total_reg) + CNT_W'(1)))
        else $error("allocation did not update the used count");

endmodule

`default_nettype wire
